// ===== rtl/core/iff_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared sizes, selector codes, state type and character helpers.
// ----------------------------------------------------------------------------
package iff_pkg;

  // Formatting limits.
  localparam int VALUE_WIDTH     = 32;
  localparam int DIGIT_BUF_DEPTH = 32;
  localparam int MAX_FIELD       = 31;

  // Digit store holds enough digits for the longest natural form (octal).
  localparam int NDIG      = (VALUE_WIDTH + 2) / 3;
  localparam int DIG_IDX_W = $clog2(NDIG);
  localparam int CNT_W     = $clog2(VALUE_WIDTH);
  // Positions span sign, prefix and the widest digit run or field.
  localparam int POS_W     = 7;

  // Base selector codes. The reserved code is formatted as decimal.
  localparam logic [1:0] BASE_DEC  = 2'd0;
  localparam logic [1:0] BASE_HEX  = 2'd1;
  localparam logic [1:0] BASE_OCT  = 2'd2;
  localparam logic [1:0] BASE_RSVD = 2'd3;

  // Sign selector codes. The reserved code prints no sign.
  localparam logic [1:0] SIGN_NONE  = 2'd0;
  localparam logic [1:0] SIGN_MINUS = 2'd1;
  localparam logic [1:0] SIGN_SPACE = 2'd2;
  localparam logic [1:0] SIGN_RSVD  = 2'd3;

  // ASCII characters used by the sequencer.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // Digit tables, written high digit first so that element d holds digit d.
  localparam logic [15:0][7:0] HEX_UPPER = "FEDCBA9876543210";
  localparam logic [15:0][7:0] HEX_LOWER = "fedcba9876543210";

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_PLAN,
    ST_EMIT
  } iff_state_t;

  typedef logic [NDIG-1:0][3:0] iff_digits_t;

  // Map one digit value to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    digit_char = upper ? HEX_UPPER[d] : HEX_LOWER[d];
  endfunction

endpackage

// ===== rtl/core/iff_in_if.sv =====
// ----------------------------------------------------------------------------
// Formatter input channel
// Valid/ready channel carrying one magnitude and its formatting controls.
// ----------------------------------------------------------------------------
interface iff_in_if import iff_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [1:0]             base_sel;
  logic [4:0]             field_width;
  logic [4:0]             min_digits;
  logic                   left_just;
  logic                   zero_fill;
  logic                   caps;
  logic [1:0]             sign_char;
  logic                   alt_prefix;

  modport source (
    output valid, magnitude, base_sel, field_width, min_digits, left_just,
           zero_fill, caps, sign_char, alt_prefix,
    input  ready
  );

  modport sink (
    input  valid, magnitude, base_sel, field_width, min_digits, left_just,
           zero_fill, caps, sign_char, alt_prefix,
    output ready
  );
endinterface

// ===== rtl/core/iff_out_if.sv =====
// ----------------------------------------------------------------------------
// Formatter output channel
// Valid/ready channel carrying one ASCII character and its last marker.
// ----------------------------------------------------------------------------
interface iff_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (
    output valid, out_char, last,
    input  ready
  );

  modport sink (
    input  valid, out_char, last,
    output ready
  );
endinterface

// ===== rtl/core/integer_field_formatter_top.sv =====
// ----------------------------------------------------------------------------
// Integer field formatter
// Turns one unsigned magnitude into a padded, signed, prefixed ASCII field.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one magnitude with its controls (base, field width,
//   minimum digits, alignment, zero padding, case, sign, alternate form).
//   out_chan returns the field one character per transaction, with last set
//   on the final character. Each field yields 1 to 34 characters.
// Sequencing:
//   Decimal values pass through a shift-and-add-3 converter, one bit per
//   cycle, before sizing; hexadecimal and octal digits are sliced directly.
//   The ST_SIZE and ST_PLAN states then size the field, and the emitter
//   sends one character per cycle into the output register while the
//   output is not stalled. in_chan.ready is high only when idle, so a new
//   magnitude is accepted only after the previous field's final character
//   has been loaded into the output register.
// Reset:
//   rst_n is synchronous, active low; it returns the sequencer to idle and
//   drops the output valid. No clearing pass is needed.
// Stalls:
//   When out_chan.ready is low the output register holds its character and
//   the emitter waits; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module integer_field_formatter_top import iff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  iff_in_if.sink    in_chan,
  iff_out_if.source out_chan
);

  iff_state_t state_r, state_nxt;

  // Captured controls.
  logic [1:0]       base_r;
  logic [4:0]       width_r;
  logic [4:0]       mind_r;
  logic             left_r;
  logic             zpad_r;
  logic             upper_r;
  logic [1:0]       sign_r;
  logic             alt_r;

  // Shared conversion unit.
  iff_digits_t            dig_r;
  iff_digits_t            dig_adj;
  logic [VALUE_WIDTH-1:0] bin_r;
  logic [CNT_W-1:0]       bit_cnt_r;
  logic [4*NDIG+VALUE_WIDTH-1:0] dd_shift;

  // Field plan.
  logic [POS_W-1:0] ndig_r;
  logic [POS_W-1:0] b_sign_r, b_pfx_r, b_zp_r, b_dig_r, b_tail_r, total_m1_r;
  logic [POS_W-1:0] pos_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;

  logic             in_ready;
  logic             in_acc;
  logic             emit_go;
  logic             is_last;
  logic [7:0]       ch;
  logic [POS_W-1:0] nat_dig;
  logic [POS_W-1:0] min_dig_c;
  logic [POS_W-1:0] width_c;
  logic [POS_W-1:0] sign_len;
  logic [POS_W-1:0] pfx_len;
  logic [POS_W-1:0] content;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] lead;
  logic [POS_W-1:0] zp;
  logic [POS_W-1:0] tail;
  logic [POS_W-1:0] dig_pos;
  logic [4*NDIG-1:0]  hex_ext;
  logic [3*NDIG-1:0]  oct_ext;

  // Sequencer controls.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    emit_go  = (state_r == ST_EMIT) && (!out_valid_r || out_chan.ready);
  end

  assign in_acc        = in_chan.valid && in_ready;
  assign in_chan.ready = in_ready;
  assign is_last       = (pos_r == total_m1_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_chan.base_sel == BASE_HEX || in_chan.base_sel == BASE_OCT) begin
            state_nxt = ST_SIZE;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (bit_cnt_r == '0) begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: state_nxt = ST_PLAN;
      ST_PLAN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Double dabble step: add 3 to every digit of five or more, then shift.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      dig_adj[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    dd_shift = {dig_adj[NDIG-1:0], bin_r} << 1;
  end

  // Zero-extended magnitude for direct hex and octal slicing.
  assign hex_ext = (4*NDIG)'(in_chan.magnitude);
  assign oct_ext = (3*NDIG)'(in_chan.magnitude);

  // Natural digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    nat_dig = POS_W'(1);
    for (int i = 0; i < NDIG; i++) begin
      if (dig_r[i] != 4'd0) begin
        nat_dig = POS_W'(i + 1);
      end
    end
    min_dig_c = (POS_W'(mind_r) > POS_W'(DIGIT_BUF_DEPTH)) ?
                POS_W'(DIGIT_BUF_DEPTH) : POS_W'(mind_r);
  end

  // Field layout from the digit count and the controls.
  always_comb begin
    width_c  = (POS_W'(width_r) > POS_W'(MAX_FIELD)) ? POS_W'(MAX_FIELD) : POS_W'(width_r);
    sign_len = (sign_r == SIGN_MINUS || sign_r == SIGN_SPACE) ? POS_W'(1) : '0;
    if (alt_r && base_r == BASE_HEX) begin
      pfx_len = POS_W'(2);
    end else if (alt_r && base_r == BASE_OCT) begin
      pfx_len = POS_W'(1);
    end else begin
      pfx_len = '0;
    end
    content = ndig_r + sign_len + pfx_len;
    pad     = (width_c > content) ? width_c - content : '0;
    lead    = (!left_r && !zpad_r) ? pad : '0;
    zp      = (!left_r && zpad_r) ? pad : '0;
    tail    = left_r ? pad : '0;
  end

  // Character at the current position.
  always_comb begin
    dig_pos = b_tail_r - pos_r - POS_W'(1);
    if (pos_r < b_sign_r) begin
      ch = CH_SPACE;
    end else if (pos_r < b_pfx_r) begin
      ch = (sign_r == SIGN_MINUS) ? CH_MINUS : CH_SPACE;
    end else if (pos_r < b_zp_r) begin
      if (pos_r == b_pfx_r) begin
        ch = CH_ZERO;
      end else begin
        ch = upper_r ? CH_X_UP : CH_X_LO;
      end
    end else if (pos_r < b_dig_r) begin
      ch = CH_ZERO;
    end else if (pos_r < b_tail_r) begin
      if (dig_pos < POS_W'(NDIG)) begin
        ch = digit_char(dig_r[dig_pos[DIG_IDX_W-1:0]], upper_r);
      end else begin
        ch = CH_ZERO;
      end
    end else begin
      ch = CH_SPACE;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r  <= in_chan.base_sel;
      width_r <= in_chan.field_width;
      mind_r  <= in_chan.min_digits;
      left_r  <= in_chan.left_just;
      zpad_r  <= in_chan.zero_fill;
      upper_r <= in_chan.caps;
      sign_r  <= in_chan.sign_char;
      alt_r   <= in_chan.alt_prefix;
      bin_r     <= in_chan.magnitude;
      bit_cnt_r <= CNT_W'(VALUE_WIDTH - 1);
      for (int i = 0; i < NDIG; i++) begin
        if (in_chan.base_sel == BASE_HEX) begin
          dig_r[i] <= hex_ext[4*i +: 4];
        end else if (in_chan.base_sel == BASE_OCT) begin
          dig_r[i] <= {1'b0, oct_ext[3*i +: 3]};
        end else begin
          dig_r[i] <= 4'd0;
        end
      end
    end else if (state_r == ST_CONV) begin
      dig_r     <= dd_shift[4*NDIG+VALUE_WIDTH-1:VALUE_WIDTH];
      bin_r     <= dd_shift[VALUE_WIDTH-1:0];
      bit_cnt_r <= bit_cnt_r - CNT_W'(1);
    end

    if (state_r == ST_SIZE) begin
      ndig_r <= (nat_dig > min_dig_c) ? nat_dig : min_dig_c;
    end

    if (state_r == ST_PLAN) begin
      b_sign_r   <= lead;
      b_pfx_r    <= lead + sign_len;
      b_zp_r     <= lead + sign_len + pfx_len;
      b_dig_r    <= lead + sign_len + pfx_len + zp;
      b_tail_r   <= lead + content + zp;
      total_m1_r <= lead + content + zp + tail - POS_W'(1);
      pos_r      <= '0;
    end else if (emit_go) begin
      pos_r <= pos_r + POS_W'(1);
    end

    if (emit_go) begin
      out_char_r <= ch;
      out_last_r <= is_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_char = out_char_r;
  assign out_chan.last     = out_last_r;

`ifndef SYNTHESIS
  // An accepted transaction goes to conversion or straight to sizing.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_CONV || state_r == ST_SIZE))
    else $error("accepted transaction did not start conversion or sizing");

  // The emitter never runs past the planned field length.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (pos_r <= total_m1_r))
    else $error("emit position beyond end of field");

  // Sending the final character returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && is_last) |=> (state_r == ST_IDLE && out_valid_r && out_last_r))
    else $error("final character did not end the field");

  // Only decimal values use the conversion loop.
  a_conv_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (base_r != BASE_HEX && base_r != BASE_OCT))
    else $error("conversion loop entered for hex or octal");
`endif

endmodule

// ===== verif/integer_field_formatter_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Sends magnitudes with formatting controls through the input channel and
// compares every returned character against a behavioral formatter, under
// random idling, a long output hold-off and a drained pause of the sender.
// ----------------------------------------------------------------------------
module integer_field_formatter_top_test;
  import iff_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          SETTLE      = 50;
  localparam logic [7:0]  CH_A_UP     = 8'h41;
  localparam logic [7:0]  CH_A_LO     = 8'h61;

  // One formatting request as driven on the input channel.
  typedef struct {
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [1:0]             base_sel;
    logic [4:0]             field_width;
    logic [4:0]             min_digits;
    logic                   left_just;
    logic                   zero_fill;
    logic                   caps;
    logic [1:0]             sign_char;
    logic                   alt_prefix;
  } fmt_req_t;

  // One expected output character.
  typedef struct {
    logic [7:0] ch;
    logic       is_last;
  } fmt_char_t;

  logic clk;
  logic rst_n;

  iff_in_if  in_chan ();
  iff_out_if out_chan ();

  integer_field_formatter_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  fmt_char_t pending_chars[$];
  int        error_count   = 0;
  int        fields_sent   = 0;
  int        chars_checked = 0;
  int        cycle_count   = 0;
  int        hold_off_left = 0;
  bit        idling_on     = 1'b1;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d characters outstanding.",
               cycle_count, pending_chars.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Build the expected character sequence of one field.
  function automatic void format_expected(input fmt_req_t r);
    logic [7:0]             digits[$];
    logic [7:0]             field[$];
    logic [VALUE_WIDTH-1:0] v;
    logic [7:0]             d;
    fmt_char_t              c;
    int                     radix;
    int                     sign_len;
    int                     pfx_len;
    int                     pad;
    v     = r.magnitude;
    radix = (r.base_sel == BASE_HEX) ? 16 : (r.base_sel == BASE_OCT) ? 8 : 10;
    // Digits, most significant first, then leading zeros up to the minimum.
    if (v == '0)
      digits.push_front(CH_ZERO);
    while (v != '0) begin
      d = 8'(v % radix);
      if (d < 10)
        digits.push_front(8'(CH_ZERO + d));
      else
        digits.push_front(8'((r.caps ? CH_A_UP : CH_A_LO) + d - 10));
      v = v / radix;
    end
    while (digits.size() < int'(r.min_digits))
      digits.push_front(CH_ZERO);
    sign_len = (r.sign_char == SIGN_MINUS || r.sign_char == SIGN_SPACE) ? 1 : 0;
    pfx_len  = !r.alt_prefix ? 0 : (radix == 16) ? 2 : (radix == 8) ? 1 : 0;
    pad      = int'(r.field_width) - digits.size() - sign_len - pfx_len;
    if (pad < 0)
      pad = 0;
    // Assemble the field in emission order.
    if (!r.left_just && !r.zero_fill)
      repeat (pad) field.push_back(CH_SPACE);
    if (r.sign_char == SIGN_MINUS)
      field.push_back(CH_MINUS);
    else if (r.sign_char == SIGN_SPACE)
      field.push_back(CH_SPACE);
    if (pfx_len > 0)
      field.push_back(CH_ZERO);
    if (pfx_len == 2)
      field.push_back(r.caps ? CH_X_UP : CH_X_LO);
    if (!r.left_just && r.zero_fill)
      repeat (pad) field.push_back(CH_ZERO);
    foreach (digits[i])
      field.push_back(digits[i]);
    if (r.left_just)
      repeat (pad) field.push_back(CH_SPACE);
    foreach (field[i]) begin
      c.ch      = field[i];
      c.is_last = (i == field.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Send one request and wait until it is accepted; may idle afterwards.
  task automatic send_field(input fmt_req_t r);
    int gap;
    @(negedge clk);
    in_chan.magnitude   = r.magnitude;
    in_chan.base_sel    = r.base_sel;
    in_chan.field_width = r.field_width;
    in_chan.min_digits  = r.min_digits;
    in_chan.left_just   = r.left_just;
    in_chan.zero_fill   = r.zero_fill;
    in_chan.caps        = r.caps;
    in_chan.sign_char   = r.sign_char;
    in_chan.alt_prefix  = r.alt_prefix;
    in_chan.valid       = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    format_expected(r);
    fields_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_chan.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Build a request from explicit values.
  function automatic fmt_req_t make_req(input logic [31:0] mag, input logic [1:0] base,
                                        input int width, input int mdig,
                                        input int left, input int zpad,
                                        input int upper, input logic [1:0] sign,
                                        input int alt);
    fmt_req_t r;
    r.magnitude   = mag;
    r.base_sel    = base;
    r.field_width = 5'(width);
    r.min_digits  = 5'(mdig);
    r.left_just   = 1'(left);
    r.zero_fill   = 1'(zpad);
    r.caps        = 1'(upper);
    r.sign_char   = sign;
    r.alt_prefix  = 1'(alt);
    return r;
  endfunction

  // Random request with magnitudes of varied bit length.
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    r.magnitude = $urandom() >> $urandom_range(0, 31);
    if ($urandom_range(0, 15) == 0)
      r.magnitude = '0;
    else if ($urandom_range(0, 15) == 0)
      r.magnitude = $urandom();
    r.base_sel    = 2'($urandom_range(0, 3));
    r.field_width = 5'($urandom_range(0, 31));
    r.min_digits  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 12));
    r.left_just   = 1'($urandom_range(0, 1));
    r.zero_fill   = 1'($urandom_range(0, 1));
    r.caps        = 1'($urandom_range(0, 1));
    r.sign_char   = 2'($urandom_range(0, 3));
    r.alt_prefix  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Stop offering and wait until every expected character has arrived.
  task automatic drain_fields();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_chars.size() != 0)
      @(posedge clk);
  endtask

  // Output side: random stalls plus an optional long hold-off.
  initial begin
    int stall_left;
    stall_left     = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_chan.ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        out_chan.ready = 1'b0;
        stall_left     = $urandom_range(1, 15) - 1;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest expected character.
  always @(posedge clk) begin
    fmt_char_t exp_c;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h with last %b", out_chan.out_char, out_chan.last);
        error_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        chars_checked++;
        if (out_chan.out_char !== exp_c.ch) begin
          $error("out_char mismatch: expected %h, actual %h", exp_c.ch, out_chan.out_char);
          error_count++;
        end
        if (out_chan.last !== exp_c.is_last) begin
          $error("last mismatch: expected %b, actual %b", exp_c.is_last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  // Extremes, every base and sign code, and the special cases.
  task automatic test_directed_fields();
    send_field(make_req(32'd0, BASE_DEC, 0, 0, 0, 0, 0, SIGN_NONE, 0));
    send_field(make_req(32'hFFFFFFFF, BASE_DEC, 0, 0, 0, 0, 0, SIGN_NONE, 0));
    send_field(make_req(32'hFFFFFFFF, BASE_HEX, 31, 0, 0, 1, 1, SIGN_MINUS, 1));
    send_field(make_req(32'hFFFFFFFF, BASE_OCT, 0, 0, 0, 0, 0, SIGN_NONE, 1));
    send_field(make_req(32'd0, BASE_OCT, 4, 0, 0, 0, 0, SIGN_NONE, 1));
    send_field(make_req(32'd0, BASE_HEX, 8, 0, 0, 1, 0, SIGN_SPACE, 1));
    // The reserved base selector falls back to decimal.
    send_field(make_req(32'd12345, BASE_RSVD, 10, 0, 0, 0, 1, SIGN_NONE, 1));
    // The reserved sign selector prints no sign.
    send_field(make_req(32'd987, BASE_DEC, 6, 0, 0, 0, 0, SIGN_RSVD, 0));
    // Zero padding is ignored when left aligned.
    send_field(make_req(32'hBEEF, BASE_HEX, 12, 0, 1, 1, 0, SIGN_MINUS, 1));
    // Decimal alternate form adds nothing.
    send_field(make_req(32'd42, BASE_DEC, 5, 0, 0, 1, 0, SIGN_NONE, 1));
    // Content wider than the field is never cut.
    send_field(make_req(32'd123456, BASE_DEC, 3, 0, 0, 0, 0, SIGN_MINUS, 0));
    // Longest possible field: sign, prefix and 31 digits.
    send_field(make_req(32'h1, BASE_HEX, 31, 31, 0, 0, 1, SIGN_MINUS, 1));
    send_field(make_req(32'h7, BASE_OCT, 31, 31, 1, 0, 0, SIGN_SPACE, 1));
    send_field(make_req(32'hABCDEF01, BASE_HEX, 12, 0, 0, 0, 0, SIGN_SPACE, 1));
    send_field(make_req(32'hABCDEF01, BASE_HEX, 20, 0, 1, 0, 1, SIGN_NONE, 0));
    send_field(make_req(32'd511, BASE_OCT, 10, 5, 0, 1, 0, SIGN_MINUS, 1));
    send_field(make_req(32'd0, BASE_DEC, 31, 0, 1, 0, 0, SIGN_NONE, 0));
    send_field(make_req(32'd0, BASE_DEC, 31, 0, 0, 1, 0, SIGN_MINUS, 0));
    send_field(make_req(32'd7, BASE_DEC, 0, 31, 0, 0, 0, SIGN_NONE, 0));
    send_field(make_req(32'h80000000, BASE_DEC, 16, 12, 0, 1, 0, SIGN_SPACE, 0));
    send_field(make_req(32'h55555555, BASE_OCT, 15, 0, 0, 0, 1, SIGN_NONE, 0));
    drain_fields();
  endtask

  // Output held off for a long stretch while requests keep coming.
  task automatic test_output_hold_off();
    @(negedge clk);
    hold_off_left = 400;
    repeat (30) send_field(random_req());
    drain_fields();
  endtask

  // Random requests with idling on both sides.
  task automatic test_random_fields();
    repeat (150) send_field(random_req());
  endtask

  // Sender pauses until every expected character has come back.
  task automatic test_drained_pauses();
    repeat (4) begin
      repeat (5) send_field(random_req());
      drain_fields();
    end
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_full_rate();
    idling_on = 1'b0;
    repeat (40) send_field(random_req());
    drain_fields();
  endtask

  // Main sequence.
  initial begin
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.magnitude   = '0;
    in_chan.base_sel    = BASE_DEC;
    in_chan.field_width = '0;
    in_chan.min_digits  = '0;
    in_chan.left_just   = 1'b0;
    in_chan.zero_fill   = 1'b0;
    in_chan.caps        = 1'b0;
    in_chan.sign_char   = SIGN_NONE;
    in_chan.alt_prefix  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed_fields();
    test_output_hold_off();
    test_random_fields();
    test_drained_pauses();
    test_full_rate();

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d fields in all bases, sign codes and padding modes;", fields_sent);
    $display("checked %0d characters under idling, hold-off and full rate.",
             chars_checked);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/iff_pkg.sv
rtl/core/iff_in_if.sv
rtl/core/iff_out_if.sv
rtl/core/integer_field_formatter_top.sv
verif/integer_field_formatter_top_test.sv
